FILE: rtl/core/mibp_pkg.sv
package mibp_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH   = 2'd0,
		CFG_MASK_ENABLE   = 2'd1,
		CFG_INACTIVE_MODE = 2'd2
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W   = 2;
	localparam int unsigned WIDTH_W       = 13;
	localparam int unsigned MAX_WIDTH_DEF = 4096;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd32;

	// Luminance in integer form: 299r + 587g + 114b compared against 128 * 1000.
	localparam int unsigned LUM_W = 18;
	localparam logic [LUM_W-1:0] LUM_COEF_R = 18'd299;
	localparam logic [LUM_W-1:0] LUM_COEF_G = 18'd587;
	localparam logic [LUM_W-1:0] LUM_COEF_B = 18'd114;
	localparam logic [LUM_W-1:0] LUM_LIMIT  = 18'd128000;

	// Marker colour that always gives a set pixel bit, before mask and checkerboard.
	localparam logic [7:0] MARK_R = 8'd66;
	localparam logic [7:0] MARK_G = 8'd154;
	localparam logic [7:0] MARK_B = 8'd167;

	// Checkerboard patterns for inactive mode.
	localparam logic [7:0] CHECKER_ODD  = 8'hAA;
	localparam logic [7:0] CHECKER_EVEN = 8'h55;

	localparam logic [2:0] LAST_BIT = 3'd7;

	// Pixel item as held in the input register.
	typedef struct packed {
		logic       start_of_image;
		logic [7:0] mask_byte;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[7-k] = v[k];
		end
		return r;
	endfunction

	function automatic logic pixel_bit(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [LUM_W-1:0] lum;
		lum = LUM_W'(r) * LUM_COEF_R + LUM_W'(g) * LUM_COEF_G + LUM_W'(b) * LUM_COEF_B;
		return (lum < LUM_LIMIT) || (r == MARK_R && g == MARK_G && b == MARK_B);
	endfunction

endpackage

FILE: rtl/core/mono_icon_bit_packer.sv
// Channel   | Dir | Handshake                       | Contents
// s_axis    | in  | s_axis_tvalid / s_axis_tready   | one pixel word: RGB, mask byte, start flag
// m_axis    | out | m_axis_tvalid / m_axis_tready   | one packed byte, tlast closes a row
// cfg       | in  | cfg_valid / cfg_ready           | register index and write data
//
// One pixel word is taken per clock while the input register can pass its pixel on.
// A pixel is held in the input register; a byte that it completes is written to the
// output register when the pixel moves on. Reset clears the position state and loads
// the register defaults. A stalled output blocks only pixels that complete a byte;
// pixels that just add a bit keep flowing into the partial byte.
module mono_icon_bit_packer #(
	parameter int unsigned MAX_WIDTH = mibp_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Pixel input. tdata, from bit 0 up: red[7:0], green[7:0], blue[7:0], mask_byte[7:0].
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [31:0]                         s_axis_tdata,
	// tuser: start_of_image.
	input  logic                                s_axis_tuser,
	// Byte output. tdata, from bit 0 up: mono_byte[7:0]. tlast: end_of_row.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [7:0]                          m_axis_tdata,
	output logic                                m_axis_tlast,
	// Configuration writes.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mibp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mibp_pkg::WIDTH_W-1:0]        cfg_data
);

	// Column counter covers 0 .. MAX_WIDTH-1; the compare width also holds the
	// widest register value and MAX_WIDTH itself.
	localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned CMP_W = (COL_W + 1 > mibp_pkg::WIDTH_W + 1) ?
		COL_W + 1 : mibp_pkg::WIDTH_W + 1;

	// Configuration registers.
	logic [mibp_pkg::WIDTH_W-1:0] image_width_q;
	logic                         mask_enable_q;
	logic                         inactive_mode_q;

	// Input register.
	logic             v_s1;
	mibp_pkg::pixel_t pix_s1;

	// Position state.
	logic [2:0]       bit_pos_q;
	logic [7:0]       partial_q;
	logic [COL_W-1:0] column_q;
	logic             row_odd_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	// Combinational next values.
	logic             produce;
	logic             advance;
	logic [2:0]       bit_pos_cur;
	logic [7:0]       partial_cur;
	logic [COL_W-1:0] column_cur;
	logic             row_odd_cur;
	logic             row_odd_nxt;
	logic [7:0]       partial_nxt;
	logic [CMP_W-1:0] eff_width;
	logic             last;
	logic             full;
	logic [7:0]       byte_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= mibp_pkg::WIDTH_RESET;
			mask_enable_q   <= 1'b0;
			inactive_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (mibp_pkg::cfg_reg_t'(cfg_index))
				mibp_pkg::CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				mibp_pkg::CFG_MASK_ENABLE:   mask_enable_q   <= cfg_data[0];
				mibp_pkg::CFG_INACTIVE_MODE: inactive_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A start-of-image pixel sees cleared position state.
	always_comb begin
		bit_pos_cur = pix_s1.start_of_image ? 3'd0 : bit_pos_q;
		partial_cur = pix_s1.start_of_image ? 8'd0 : partial_q;
		column_cur  = pix_s1.start_of_image ? '0 : column_q;
		row_odd_cur = pix_s1.start_of_image ? 1'b0 : row_odd_q;
		// Row parity flips on the first pixel of every row.
		row_odd_nxt = (column_cur == '0) ? !row_odd_cur : row_odd_cur;

		partial_nxt = partial_cur |
			(8'(mibp_pkg::pixel_bit(pix_s1.red, pix_s1.green, pix_s1.blue)) << bit_pos_cur);

		// A width of zero counts as one, anything above MAX_WIDTH as MAX_WIDTH.
		if (image_width_q == '0) begin
			eff_width = CMP_W'(1);
		end else if (CMP_W'(image_width_q) > CMP_W'(MAX_WIDTH)) begin
			eff_width = CMP_W'(MAX_WIDTH);
		end else begin
			eff_width = CMP_W'(image_width_q);
		end
		last = (CMP_W'(column_cur) + CMP_W'(1)) >= eff_width;
		full = (bit_pos_cur == mibp_pkg::LAST_BIT);

		byte_out = partial_nxt;
		if (mask_enable_q) begin
			byte_out = byte_out & mibp_pkg::reverse8(pix_s1.mask_byte);
		end
		if (inactive_mode_q) begin
			byte_out = byte_out &
				(row_odd_nxt ? mibp_pkg::CHECKER_ODD : mibp_pkg::CHECKER_EVEN);
		end
	end

	// The held pixel moves on when it emits nothing or the output slot is free.
	assign produce       = full || last;
	assign advance       = v_s1 && (!produce || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pix_s1 <= {s_axis_tuser, s_axis_tdata[31:24], s_axis_tdata[23:16],
				s_axis_tdata[15:8], s_axis_tdata[7:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q <= 3'd0;
			partial_q <= 8'd0;
			column_q  <= '0;
			row_odd_q <= 1'b0;
		end else if (advance) begin
			row_odd_q <= row_odd_nxt;
			column_q  <= last ? '0 : column_cur + COL_W'(1);
			if (produce) begin
				bit_pos_q <= 3'd0;
				partial_q <= 8'd0;
			end else begin
				bit_pos_q <= bit_pos_cur + 3'd1;
				partial_q <= partial_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_byte_q <= byte_out;
			out_last_q <= last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	// Bits at or above the fill position of the partial byte are always clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		(partial_q >> bit_pos_q) == 8'd0)
		else $error("partial byte holds bits beyond its fill position");

	// The column counter never leaves the supported row length.
	assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(column_q) < CMP_W'(MAX_WIDTH))
		else $error("pixel column beyond maximum width");

	// A pixel that completes a byte presents it on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && produce) |=> m_axis_tvalid)
		else $error("completed byte not presented");

	// Input is only held off while a pixel waits in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a blocked byte");

endmodule
